### rtl/bldist_pkg.sv
// Shared types and constants for the Brown-Conrady lens distortion point unit.
`default_nettype none

package bldist_pkg;

    localparam int DATA_W    = 24;
    localparam int FRAC_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_STAGES = 11;

    localparam logic signed [DATA_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [DATA_W-1:0] S24_MIN = -24'sh800000;

    localparam logic signed [FRAC_W:0]   HALF_ULP = 21'sh080000;
    localparam logic signed [FRAC_W+1:0] Q_ONE    = 22'sh100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIAL_K1     = 3'd0,
        REG_RADIAL_K2     = 3'd1,
        REG_RADIAL_K3     = 3'd2,
        REG_TANGENTIAL_P1 = 3'd3,
        REG_TANGENTIAL_P2 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] view_x;
        logic signed [DATA_W-1:0] view_y;
    } point_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] mapped_x;
        logic signed [DATA_W-1:0] mapped_y;
        logic                     saturated;
    } result_t;

endpackage

`default_nettype wire

### rtl/brown_lens_distortion_point_unit.sv
// Eleven-stage pipelined Brown-Conrady lens distortion of one Q4.20 point per request.
// An accepted request raises done when its valid bit reaches the last stage.
// Throughput: one request per cycle; busy stays low because every stage advances each cycle.
// The stage count is set by the chain r2, r4, r6, radial scale, and the split wide products.
// Reset clears the stage valid bits and all five coefficient registers to zero.
// Results cannot be stalled: done marks each result for exactly one cycle.
`default_nettype none

module brown_lens_distortion_point_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire bldist_pkg::point_t                 point,
    output logic                                    done,
    output bldist_pkg::result_t                     result,
    input  wire logic                               cfg_we,
    input  wire logic [bldist_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bldist_pkg::DATA_W-1:0]      cfg_data
);

    logic signed [23:0] k1_reg;
    logic signed [23:0] k2_reg;
    logic signed [23:0] k3_reg;
    logic signed [23:0] p1_reg;
    logic signed [23:0] p2_reg;

    logic [bldist_pkg::NUM_STAGES-1:0] valid_reg;
    logic [bldist_pkg::NUM_STAGES-1:0] valid_next;
    logic                              accept;

    // Stage 1: squares and cross product.
    logic signed [24:0] x_in;
    logic signed [24:0] y_in;
    logic signed [49:0] xx_prod;
    logic signed [49:0] yy_prod;
    logic signed [49:0] xy_prod;
    logic signed [27:0] xx_s1_next;
    logic signed [27:0] yy_s1_next;
    logic signed [27:0] xy_s1_next;
    logic signed [27:0] xx_s1_reg;
    logic signed [27:0] yy_s1_reg;
    logic signed [27:0] xy_s1_reg;
    logic signed [24:0] x_pipe_reg [1:7];
    logic signed [24:0] y_pipe_reg [1:7];

    // Stage 2.
    logic signed [28:0] r2_s2_next;
    logic signed [29:0] tx_s2_next;
    logic signed [29:0] ty_s2_next;
    logic signed [51:0] pxy1_prod;
    logic signed [51:0] pxy2_prod;
    logic signed [30:0] pxy1_s2_next;
    logic signed [30:0] pxy2_s2_next;
    logic signed [28:0] r2_s2_reg;
    logic signed [29:0] tx_s2_reg;
    logic signed [29:0] ty_s2_reg;
    logic signed [30:0] pxy1_s2_reg;
    logic signed [30:0] pxy2_s2_reg;

    // Stage 3.
    logic signed [57:0] r4_prod;
    logic signed [52:0] k1r2_prod;
    logic signed [53:0] tpx_prod;
    logic signed [53:0] tpy_prod;
    logic signed [35:0] r4_s3_next;
    logic signed [31:0] k1r2_s3_next;
    logic signed [32:0] tpx_s3_next;
    logic signed [32:0] tpy_s3_next;
    logic signed [35:0] r4_s3_reg;
    logic signed [31:0] k1r2_s3_reg;
    logic signed [32:0] tpx_s3_reg;
    logic signed [32:0] tpy_s3_reg;
    logic signed [28:0] r2_s3_reg;
    logic signed [30:0] pxy1_s3_reg;
    logic signed [30:0] pxy2_s3_reg;

    // Stage 4.
    logic signed [64:0] r6_prod;
    logic signed [59:0] k2r4_prod;
    logic signed [42:0] r6_s4_next;
    logic signed [38:0] k2r4_s4_next;
    logic signed [34:0] tanx_s4_next;
    logic signed [34:0] tany_s4_next;
    logic signed [42:0] r6_s4_reg;
    logic signed [38:0] k2r4_s4_reg;
    logic signed [31:0] k1r2_s4_reg;
    logic signed [34:0] tanx_pipe_reg [4:9];
    logic signed [34:0] tany_pipe_reg [4:9];

    // Stage 5: split k3 * r6 into two partial products.
    logic signed [45:0] pp_hi_s5_next;
    logic signed [45:0] pp_lo_s5_next;
    logic signed [39:0] spart_s5_next;
    logic signed [45:0] pp_hi_s5_reg;
    logic signed [45:0] pp_lo_s5_reg;
    logic signed [39:0] spart_s5_reg;

    // Stage 6.
    logic signed [67:0] k3r6_sum;
    logic signed [45:0] k3r6_s6_next;
    logic signed [45:0] k3r6_s6_reg;
    logic signed [39:0] spart_s6_reg;

    // Stage 7: radial scale.
    logic signed [46:0] s_s7_next;
    logic signed [46:0] s_s7_reg;

    // Stage 8: split x * s and y * s into partial products.
    logic signed [23:0] s_lo;
    logic signed [23:0] s_hi;
    logic signed [48:0] xpl_s8_next;
    logic signed [48:0] xph_s8_next;
    logic signed [48:0] ypl_s8_next;
    logic signed [48:0] yph_s8_next;
    logic signed [48:0] xpl_s8_reg;
    logic signed [48:0] xph_s8_reg;
    logic signed [48:0] ypl_s8_reg;
    logic signed [48:0] yph_s8_reg;

    // Stage 9.
    logic signed [72:0] xs_sum;
    logic signed [72:0] ys_sum;
    logic signed [51:0] xs_s9_next;
    logic signed [51:0] ys_s9_next;
    logic signed [51:0] xs_s9_reg;
    logic signed [51:0] ys_s9_reg;

    // Stage 10: final sums, y negated back.
    logic signed [52:0] ox_s10_next;
    logic signed [52:0] oy_s10_next;
    logic signed [52:0] ox_s10_reg;
    logic signed [52:0] oy_s10_reg;

    // Stage 11: saturation.
    logic                sat_x;
    logic                sat_y;
    bldist_pkg::result_t out_next;
    bldist_pkg::result_t out_reg;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[bldist_pkg::NUM_STAGES-2:0], accept};

    assign x_in    = $signed({point.view_x[23], point.view_x});
    assign y_in    = -$signed({point.view_y[23], point.view_y});
    assign xx_prod = x_in * x_in + bldist_pkg::HALF_ULP;
    assign yy_prod = y_in * y_in + bldist_pkg::HALF_ULP;
    assign xy_prod = x_in * y_in + bldist_pkg::HALF_ULP;
    assign xx_s1_next = xx_prod[bldist_pkg::FRAC_W +: 28];
    assign yy_s1_next = yy_prod[bldist_pkg::FRAC_W +: 28];
    assign xy_s1_next = xy_prod[bldist_pkg::FRAC_W +: 28];

    assign r2_s2_next   = xx_s1_reg + yy_s1_reg;
    assign tx_s2_next   = xx_s1_reg + (xx_s1_reg <<< 1) + yy_s1_reg;
    assign ty_s2_next   = yy_s1_reg + (yy_s1_reg <<< 1) + xx_s1_reg;
    assign pxy1_prod    = p1_reg * xy_s1_reg + bldist_pkg::HALF_ULP;
    assign pxy2_prod    = p2_reg * xy_s1_reg + bldist_pkg::HALF_ULP;
    assign pxy1_s2_next = pxy1_prod[bldist_pkg::FRAC_W +: 31];
    assign pxy2_s2_next = pxy2_prod[bldist_pkg::FRAC_W +: 31];

    assign r4_prod      = r2_s2_reg * r2_s2_reg + bldist_pkg::HALF_ULP;
    assign k1r2_prod    = k1_reg * r2_s2_reg + bldist_pkg::HALF_ULP;
    assign tpx_prod     = p2_reg * tx_s2_reg + bldist_pkg::HALF_ULP;
    assign tpy_prod     = p1_reg * ty_s2_reg + bldist_pkg::HALF_ULP;
    assign r4_s3_next   = r4_prod[bldist_pkg::FRAC_W +: 36];
    assign k1r2_s3_next = k1r2_prod[bldist_pkg::FRAC_W +: 32];
    assign tpx_s3_next  = tpx_prod[bldist_pkg::FRAC_W +: 33];
    assign tpy_s3_next  = tpy_prod[bldist_pkg::FRAC_W +: 33];

    assign r6_prod      = r4_s3_reg * r2_s3_reg + bldist_pkg::HALF_ULP;
    assign k2r4_prod    = k2_reg * r4_s3_reg + bldist_pkg::HALF_ULP;
    assign r6_s4_next   = r6_prod[bldist_pkg::FRAC_W +: 43];
    assign k2r4_s4_next = k2r4_prod[bldist_pkg::FRAC_W +: 39];
    assign tanx_s4_next = tpx_s3_reg + (pxy1_s3_reg <<< 1);
    assign tany_s4_next = tpy_s3_reg + (pxy2_s3_reg <<< 1);

    assign pp_hi_s5_next = k3_reg * $signed(r6_s4_reg[42:21]);
    assign pp_lo_s5_next = k3_reg * $signed({1'b0, r6_s4_reg[20:0]});
    assign spart_s5_next = bldist_pkg::Q_ONE + k1r2_s4_reg + k2r4_s4_reg;

    assign k3r6_sum     = (pp_hi_s5_reg <<< 21) + pp_lo_s5_reg + bldist_pkg::HALF_ULP;
    assign k3r6_s6_next = k3r6_sum[bldist_pkg::FRAC_W +: 46];

    assign s_s7_next = spart_s6_reg + k3r6_s6_reg;

    assign s_lo        = $signed({1'b0, s_s7_reg[22:0]});
    assign s_hi        = $signed(s_s7_reg[46:23]);
    assign xpl_s8_next = x_pipe_reg[7] * s_lo;
    assign xph_s8_next = x_pipe_reg[7] * s_hi;
    assign ypl_s8_next = y_pipe_reg[7] * s_lo;
    assign yph_s8_next = y_pipe_reg[7] * s_hi;

    assign xs_sum     = (xph_s8_reg <<< 23) + xpl_s8_reg + bldist_pkg::HALF_ULP;
    assign ys_sum     = (yph_s8_reg <<< 23) + ypl_s8_reg + bldist_pkg::HALF_ULP;
    assign xs_s9_next = xs_sum[bldist_pkg::FRAC_W +: 52];
    assign ys_s9_next = ys_sum[bldist_pkg::FRAC_W +: 52];

    assign ox_s10_next = xs_s9_reg + tanx_pipe_reg[9];
    assign oy_s10_next = -ys_s9_reg - tany_pipe_reg[9];

    always_comb
    begin
        sat_x = (ox_s10_reg > bldist_pkg::S24_MAX) || (ox_s10_reg < bldist_pkg::S24_MIN);
        sat_y = (oy_s10_reg > bldist_pkg::S24_MAX) || (oy_s10_reg < bldist_pkg::S24_MIN);
        if (ox_s10_reg > bldist_pkg::S24_MAX)
        begin
            out_next.mapped_x = bldist_pkg::S24_MAX;
        end
        else if (ox_s10_reg < bldist_pkg::S24_MIN)
        begin
            out_next.mapped_x = bldist_pkg::S24_MIN;
        end
        else
        begin
            out_next.mapped_x = ox_s10_reg[23:0];
        end
        if (oy_s10_reg > bldist_pkg::S24_MAX)
        begin
            out_next.mapped_y = bldist_pkg::S24_MAX;
        end
        else if (oy_s10_reg < bldist_pkg::S24_MIN)
        begin
            out_next.mapped_y = bldist_pkg::S24_MIN;
        end
        else
        begin
            out_next.mapped_y = oy_s10_reg[23:0];
        end
        out_next.saturated = sat_x || sat_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bldist_pkg::REG_RADIAL_K1:     k1_reg <= cfg_data;
                    bldist_pkg::REG_RADIAL_K2:     k2_reg <= cfg_data;
                    bldist_pkg::REG_RADIAL_K3:     k3_reg <= cfg_data;
                    bldist_pkg::REG_TANGENTIAL_P1: p1_reg <= cfg_data;
                    bldist_pkg::REG_TANGENTIAL_P2: p2_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xx_s1_reg     <= xx_s1_next;
        yy_s1_reg     <= yy_s1_next;
        xy_s1_reg     <= xy_s1_next;
        x_pipe_reg[1] <= x_in;
        y_pipe_reg[1] <= y_in;
        for (int i = 2; i <= 7; i++)
        begin
            x_pipe_reg[i] <= x_pipe_reg[i-1];
            y_pipe_reg[i] <= y_pipe_reg[i-1];
        end

        r2_s2_reg   <= r2_s2_next;
        tx_s2_reg   <= tx_s2_next;
        ty_s2_reg   <= ty_s2_next;
        pxy1_s2_reg <= pxy1_s2_next;
        pxy2_s2_reg <= pxy2_s2_next;

        r4_s3_reg   <= r4_s3_next;
        k1r2_s3_reg <= k1r2_s3_next;
        tpx_s3_reg  <= tpx_s3_next;
        tpy_s3_reg  <= tpy_s3_next;
        r2_s3_reg   <= r2_s2_reg;
        pxy1_s3_reg <= pxy1_s2_reg;
        pxy2_s3_reg <= pxy2_s2_reg;

        r6_s4_reg        <= r6_s4_next;
        k2r4_s4_reg      <= k2r4_s4_next;
        k1r2_s4_reg      <= k1r2_s3_reg;
        tanx_pipe_reg[4] <= tanx_s4_next;
        tany_pipe_reg[4] <= tany_s4_next;
        for (int j = 5; j <= 9; j++)
        begin
            tanx_pipe_reg[j] <= tanx_pipe_reg[j-1];
            tany_pipe_reg[j] <= tany_pipe_reg[j-1];
        end

        pp_hi_s5_reg <= pp_hi_s5_next;
        pp_lo_s5_reg <= pp_lo_s5_next;
        spart_s5_reg <= spart_s5_next;

        k3r6_s6_reg  <= k3r6_s6_next;
        spart_s6_reg <= spart_s5_reg;

        s_s7_reg <= s_s7_next;

        xpl_s8_reg <= xpl_s8_next;
        xph_s8_reg <= xph_s8_next;
        ypl_s8_reg <= ypl_s8_next;
        yph_s8_reg <= yph_s8_next;

        xs_s9_reg <= xs_s9_next;
        ys_s9_reg <= ys_s9_next;

        ox_s10_reg <= ox_s10_next;
        oy_s10_reg <= oy_s10_next;

        out_reg <= out_next;
    end

    assign done   = valid_reg[bldist_pkg::NUM_STAGES-1];
    assign result = out_reg;

    // Every accepted request produces a result after the full pipeline depth.
    a_request_completes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(bldist_pkg::NUM_STAGES) done)
        else $error("accepted request did not complete on time");

    // A result is only delivered for a request accepted the pipeline depth earlier.
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, bldist_pkg::NUM_STAGES))
        else $error("result delivered without a matching request");

    // A saturated result must have at least one coordinate at a range limit.
    a_saturation_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |->
            (result.mapped_x == bldist_pkg::S24_MAX) ||
            (result.mapped_x == bldist_pkg::S24_MIN) ||
            (result.mapped_y == bldist_pkg::S24_MAX) ||
            (result.mapped_y == bldist_pkg::S24_MIN))
        else $error("saturation flagged with no coordinate at a limit");

endmodule

`default_nettype wire
